// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the credit tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/act_pkg.sv -----
// Shared constants, codes and controller/datapath interface types of the credit tracker.
package act_pkg;

    localparam int MAX_LINKS_DEF = 8;
    localparam int RESULT_LIMIT  = 8;

    localparam int HANDLE_W = 12;
    localparam int COUNT_W  = 16;
    localparam int DROP_W   = 32;
    localparam int MODE_W   = 2;
    localparam int KIND_W   = 2;
    localparam int REC_W    = $clog2(RESULT_LIMIT + 1);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 80;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hffff;
    localparam logic [COUNT_W-1:0] THRESH_RESET = 16'd1;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FORGET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    // What the output register loads in a cycle.
    typedef enum logic [2:0] {
        EM_NONE,
        EM_STATUS,
        EM_EMPTY,
        EM_HOLD_MID,
        EM_HOLD_LAST
    } emit_t;

    typedef struct packed {
        logic  load_item;
        logic  scan_start;
        logic  scan_step;
        logic  capture;
        logic  take_rec;
        logic  calc;
        logic  commit_add;
        logic  commit_forget;
        emit_t emit;
    } act_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              add_zero;
        logic              flush_due;
        logic              is_rec;
        logic              scan_last;
        logic              rec_last;
        logic              hold_valid;
        logic              out_free;
    } act_sts_t;

endpackage

// ----- hw/rtl/act_ctrl.sv -----
// Sequencing state machine of the credit tracker.
`include "assert_macros.svh"

module act_ctrl import act_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  act_sts_t sts,
    output act_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_CALC,
        ST_COMMIT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    assign s_tready = s_tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                cmd.scan_start = 1'b1;
                if ((sts.mode == MODE_NONE) ||
                    (sts.mode == MODE_ADD && sts.add_zero) ||
                    (sts.mode == MODE_FLUSH && !sts.flush_due)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.mode == MODE_FLUSH) begin
                    if (sts.is_rec) begin
                        // A new record pushes the held one out, so that needs room.
                        if (!sts.hold_valid || sts.out_free) begin
                            cmd.take_rec = 1'b1;
                            if (sts.hold_valid) begin
                                cmd.emit = EM_HOLD_MID;
                            end
                            if (sts.scan_last || sts.rec_last) begin
                                state_next = ST_FIN;
                            end else begin
                                cmd.scan_step = 1'b1;
                            end
                        end
                    end else if (sts.scan_last) begin
                        state_next = ST_FIN;
                    end else begin
                        cmd.scan_step = 1'b1;
                    end
                end else begin
                    cmd.capture = 1'b1;
                    if (sts.scan_last) begin
                        state_next = (sts.mode == MODE_ADD) ? ST_CALC : ST_COMMIT;
                    end else begin
                        cmd.scan_step = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (sts.mode == MODE_ADD) begin
                    cmd.commit_add = 1'b1;
                end else begin
                    cmd.commit_forget = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    if (sts.mode == MODE_FLUSH) begin
                        cmd.emit = sts.hold_valid ? EM_HOLD_LAST : EM_EMPTY;
                    end else begin
                        cmd.emit = EM_STATUS;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == ST_IDLE);
        end
    end

    `ASSERT_CLK(a_accept_starts, s_tvalid && s_tready_reg |=> state_reg == ST_START, "accepted request did not start")
    `ASSERT_CLK(a_take_rec_room, cmd.take_rec && sts.hold_valid |-> sts.out_free, "held record overwritten")

endmodule

// ----- hw/rtl/act_datapath.sv -----
// Slot table, totals, record holding stage and output register of the credit tracker.
`include "assert_macros.svh"

module act_datapath import act_pkg::*; #(
    parameter int MAX_LINKS = MAX_LINKS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic [MODE_W-1:0]   in_mode,
    input  logic [HANDLE_W-1:0] in_handle,
    input  logic [COUNT_W-1:0]  in_add,
    input  logic                in_force,
    input  act_cmd_t            cmd,
    output act_sts_t            sts,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [KIND_W-1:0]   out_kind,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [COUNT_W-1:0]  out_count,
    output logic [COUNT_W-1:0]  out_pending,
    output logic [DROP_W-1:0]   out_dropped,
    output logic                out_last
);

    localparam int IDX_W  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int SLOT_W = HANDLE_W + COUNT_W;

    // Slot memory: count in the upper bits, handle in the lower bits.
    logic [SLOT_W-1:0]   slot_mem [MAX_LINKS];
    logic [SLOT_W-1:0]   rd_data_reg;
    logic [MAX_LINKS-1:0] used_reg;
    logic [IDX_W-1:0]    idx_reg;

    logic [COUNT_W-1:0]  thr_reg;
    logic [COUNT_W-1:0]  pending_reg;
    logic [DROP_W-1:0]   dropped_reg;

    logic [MODE_W-1:0]   mode_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [COUNT_W-1:0]  add_reg;
    logic                force_reg;

    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic [COUNT_W-1:0]  match_cnt_reg;
    logic                free_found_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [COUNT_W-1:0]  take_reg;
    logic [COUNT_W-1:0]  drop_reg;

    logic [REC_W-1:0]    rec_n_reg;
    logic                hold_valid_reg;
    logic [HANDLE_W-1:0] hold_handle_reg;
    logic [COUNT_W-1:0]  hold_count_reg;
    logic [COUNT_W-1:0]  hold_pending_reg;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [COUNT_W-1:0]  out_pending_reg;
    logic [DROP_W-1:0]   out_dropped_reg;
    logic                out_last_reg;

    logic                cur_used;
    logic [HANDLE_W-1:0] cur_handle;
    logic [COUNT_W-1:0]  cur_count;
    logic                cur_hit;
    logic [COUNT_W-1:0]  thr_eff;
    logic                out_free;
    logic                slot_ok;
    logic [IDX_W-1:0]    slot_sel;
    logic [COUNT_W-1:0]  cnt_base;
    logic [COUNT_W-1:0]  room_s;
    logic [COUNT_W-1:0]  room_p;
    logic [COUNT_W-1:0]  room;
    logic [COUNT_W-1:0]  take_calc;
    logic [COUNT_W-1:0]  pending_less_cur;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [SLOT_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_raddr;

    assign cur_used         = used_reg[idx_reg];
    assign cur_handle       = rd_data_reg[HANDLE_W-1:0];
    assign cur_count        = rd_data_reg[HANDLE_W +: COUNT_W];
    assign cur_hit          = cur_used && (cur_handle == handle_reg);
    assign thr_eff          = (thr_reg == '0) ? THRESH_RESET : thr_reg;
    assign out_free         = !out_valid_reg || out_ready;
    assign pending_less_cur = pending_reg - cur_count;

    assign slot_ok   = match_found_reg || free_found_reg;
    assign slot_sel  = match_found_reg ? match_idx_reg : free_idx_reg;
    assign cnt_base  = match_found_reg ? match_cnt_reg : '0;
    assign room_s    = COUNT_MAX - cnt_base;
    assign room_p    = COUNT_MAX - pending_reg;
    assign room      = (room_s < room_p) ? room_s : room_p;
    assign take_calc = (add_reg < room) ? add_reg : room;

    // One write port (flush clear or add commit) and one read port (scan).
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {{COUNT_W{1'b0}}, cur_handle};
        if (cmd.take_rec) begin
            mem_we = 1'b1;
        end else if (cmd.commit_add && slot_ok) begin
            mem_we    = 1'b1;
            mem_waddr = slot_sel;
            mem_wdata = {cnt_base + take_reg, handle_reg};
        end
    end

    assign mem_re    = cmd.scan_start || cmd.scan_step;
    assign mem_raddr = cmd.scan_start ? '0 : idx_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    always_comb begin
        sts            = '0;
        sts.mode       = mode_reg;
        sts.add_zero   = (add_reg == '0);
        sts.flush_due  = (pending_reg != '0) && (force_reg || pending_reg >= thr_eff);
        sts.is_rec     = cur_used && (cur_count != '0);
        sts.scan_last  = (idx_reg == IDX_W'(MAX_LINKS - 1));
        sts.rec_last   = (rec_n_reg == REC_W'(RESULT_LIMIT - 1));
        sts.hold_valid = hold_valid_reg;
        sts.out_free   = out_free;
    end

    // Table flags, totals and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg         <= THRESH_RESET;
            used_reg        <= '0;
            pending_reg     <= '0;
            dropped_reg     <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            hold_valid_reg  <= 1'b0;
            rec_n_reg       <= '0;
            idx_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.scan_start) begin
                idx_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                hold_valid_reg  <= 1'b0;
                rec_n_reg       <= '0;
            end
            if (cmd.scan_step) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.capture) begin
                if (cur_hit && !match_found_reg) begin
                    match_found_reg <= 1'b1;
                end
                if (!cur_used && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.take_rec) begin
                hold_valid_reg <= 1'b1;
                pending_reg    <= pending_less_cur;
                rec_n_reg      <= rec_n_reg + REC_W'(1);
            end
            if (cmd.commit_add) begin
                if (slot_ok) begin
                    used_reg[slot_sel] <= 1'b1;
                    pending_reg        <= pending_reg + take_reg;
                end
                dropped_reg <= dropped_reg + DROP_W'(drop_reg);
            end
            if (cmd.commit_forget && match_found_reg) begin
                used_reg[match_idx_reg] <= 1'b0;
                pending_reg             <= pending_reg - match_cnt_reg;
            end
        end
    end

    // Request fields, scan captures and held record.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mode_reg   <= in_mode;
            handle_reg <= in_handle;
            add_reg    <= in_add;
            force_reg  <= in_force;
        end
        if (cmd.capture) begin
            if (cur_hit && !match_found_reg) begin
                match_idx_reg <= idx_reg;
                match_cnt_reg <= cur_count;
            end
            if (!cur_used && !free_found_reg) begin
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.calc) begin
            take_reg <= slot_ok ? take_calc : '0;
            drop_reg <= slot_ok ? add_reg - take_calc : add_reg;
        end
        if (cmd.take_rec) begin
            hold_handle_reg  <= cur_handle;
            hold_count_reg   <= cur_count;
            hold_pending_reg <= pending_less_cur;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit != EM_NONE) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.emit)
            EM_STATUS, EM_EMPTY: begin
                out_kind_reg    <= (cmd.emit == EM_STATUS) ? KIND_STATUS : KIND_EMPTY;
                out_handle_reg  <= '0;
                out_count_reg   <= '0;
                out_pending_reg <= pending_reg;
                out_dropped_reg <= dropped_reg;
                out_last_reg    <= 1'b1;
            end
            EM_HOLD_MID, EM_HOLD_LAST: begin
                out_kind_reg    <= KIND_RECORD;
                out_handle_reg  <= hold_handle_reg;
                out_count_reg   <= hold_count_reg;
                out_pending_reg <= hold_pending_reg;
                out_dropped_reg <= dropped_reg;
                out_last_reg    <= (cmd.emit == EM_HOLD_LAST);
            end
            default: begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_handle  = out_handle_reg;
    assign out_count   = out_count_reg;
    assign out_pending = out_pending_reg;
    assign out_dropped = out_dropped_reg;
    assign out_last    = out_last_reg;

    `ASSERT_CLK(a_emit_room, cmd.emit != EM_NONE |-> out_free, "result loaded over an untaken result")
    `ASSERT_CLK(a_record_nonzero, out_valid_reg && out_kind_reg == KIND_RECORD |-> out_count_reg != '0, "empty credit record")
    `ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !out_valid_reg, "output valid survived reset")

endmodule

// ----- hw/rtl/acl_credit_tracker.sv -----
// Top level of the per-connection ACL credit tracker.
// Sequence: a request is taken in the idle cycle; an add scans every slot, works out what
//   fits and commits, a forget scans and commits, a flush scans and loads its records, and a
//   request that needs no table scan skips these steps. The last result waits for output room.
// Requests: one at a time, paced by the one-slot-per-cycle scan over the single read port
//   of the slot memory; in a flush the scan stalls while a held record waits for room.
// Reset: synchronous, active low; it empties the table, zeroes both totals and sets the
//   flush threshold to one. No clearing pass is needed.
`include "assert_macros.svh"

module acl_credit_tracker import act_pkg::*; #(
    parameter int MAX_LINKS = MAX_LINKS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Flush threshold register.
    input  logic                 cfg_wr_en,
    input  logic [COUNT_W-1:0]   cfg_wr_data,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // handle[11:0], add_count[27:12], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,   // mode[1:0], force_flush[2]
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // record_handle[11:0], record_count[27:12],
                                            // pending_after[43:28], dropped_after[75:44],
                                            // zero pad
    output logic [KIND_W-1:0]    m_tuser,   // kind[1:0]
    output logic                 m_tlast
);

    // The controller steps the scan and decides what the output register loads; the
    // datapath holds the slot table, the totals and a one-record holding stage so that
    // the final record of a flush can be marked with tlast.
    act_cmd_t cmd;
    act_sts_t sts;

    logic [HANDLE_W-1:0] out_handle;
    logic [COUNT_W-1:0]  out_count;
    logic [COUNT_W-1:0]  out_pending;
    logic [DROP_W-1:0]   out_dropped;

    act_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    act_datapath #(
        .MAX_LINKS (MAX_LINKS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_mode     (s_tuser[MODE_W-1:0]),
        .in_handle   (s_tdata[HANDLE_W-1:0]),
        .in_add      (s_tdata[HANDLE_W +: COUNT_W]),
        .in_force    (s_tuser[MODE_W]),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (m_tuser),
        .out_handle  (out_handle),
        .out_count   (out_count),
        .out_pending (out_pending),
        .out_dropped (out_dropped),
        .out_last    (m_tlast)
    );

    // Pack the result fields, lowest field first, zero filled to whole bytes.
    assign m_tdata = {{(M_TDATA_W - HANDLE_W - 2 * COUNT_W - DROP_W){1'b0}},
                      out_dropped, out_pending, out_count, out_handle};

    // Status and empty-flush results always close their request.
    `ASSERT_CLK(a_single_is_last, m_tvalid && m_tuser != KIND_RECORD |-> m_tlast, "single result without tlast")

endmodule

// ----- dv/acl_credit_tracker_test.sv -----
// Self-checking testbench for the ACL credit tracker: streamed requests, predicted results.
module acl_credit_tracker_test;
    import act_pkg::*;

    // Both sides wait between 0 and this many cycles before each transfer.
    localparam int GAP_MAX = 14;
    // Cycles allowed after the last expected result before the block counts as idle.
    localparam int SETTLE_CYCLES = 16;
    // A healthy run never goes this long without a transfer on either channel.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_REQUESTS = 74;
    localparam int POOL_SIZE = 11;

    // One result as the tracker should present it on the master side.
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] rec_handle;
        logic [COUNT_W-1:0]  rec_count;
        logic [COUNT_W-1:0]  pending_after;
        logic [DROP_W-1:0]   dropped_after;
        logic                last;
    } credit_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // handle[11:0], add_count[27:12], zero pad
    logic [S_TUSER_W-1:0] s_tuser;   // mode[1:0], force_flush[2]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // record_handle[11:0], record_count[27:12],
                                     // pending_after[43:28], dropped_after[75:44], zero pad
    logic [KIND_W-1:0]    m_tuser;   // kind[1:0]
    logic                 m_tlast;

    acl_credit_tracker uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // The scoreboard keeps its own copy of the credit table and totals. Every accepted
    // request is applied to that copy right away, and the results it should cause are
    // queued in order. Each result the tracker hands out is checked against the head.
    class credit_scoreboard;
        bit                  slot_used[MAX_LINKS_DEF];
        logic [HANDLE_W-1:0] slot_handle[MAX_LINKS_DEF];
        logic [COUNT_W-1:0]  slot_count[MAX_LINKS_DEF];
        logic [COUNT_W-1:0]  owed_credits;
        logic [DROP_W-1:0]   dropped_total;
        logic [COUNT_W-1:0]  flush_level;
        credit_result_t      expected_results[$];
        int                  mismatches;

        function new();
            for (int i = 0; i < MAX_LINKS_DEF; i++) begin
                slot_used[i] = 0;
                slot_handle[i] = '0;
                slot_count[i] = '0;
            end
            owed_credits = '0;
            dropped_total = '0;
            flush_level = THRESH_RESET;
            mismatches = 0;
        endfunction

        function void set_threshold(logic [COUNT_W-1:0] value);
            flush_level = value;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function int find_slot(logic [HANDLE_W-1:0] handle);
            for (int i = 0; i < MAX_LINKS_DEF; i++) begin
                if (slot_used[i] && slot_handle[i] == handle) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // The totals are captured at the moment the result is queued, which is the
        // value the tracker must report with that result.
        function void queue_result(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                   logic [COUNT_W-1:0] count, logic last);
            credit_result_t r;
            r.kind = kind;
            r.rec_handle = handle;
            r.rec_count = count;
            r.pending_after = owed_credits;
            r.dropped_after = dropped_total;
            r.last = last;
            expected_results.push_back(r);
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                                   logic [COUNT_W-1:0] add_count, logic force_flush);
            int                 slot;
            int unsigned        room_slot;
            int unsigned        room_total;
            int unsigned        taken;
            int                 records;
            logic [COUNT_W-1:0] threshold;
            slot = -1;
            records = 0;
            case (mode)
                MODE_ADD: begin
                    // A zero count leaves the table alone and takes no slot.
                    if (add_count != 0) begin
                        slot = find_slot(handle);
                        for (int i = 0; i < MAX_LINKS_DEF && slot < 0; i++) begin
                            if (!slot_used[i]) begin
                                slot = i;
                                slot_used[i] = 1;
                                slot_handle[i] = handle;
                                slot_count[i] = '0;
                            end
                        end
                        if (slot < 0) begin
                            // Table full: every unit is lost.
                            dropped_total = dropped_total + DROP_W'(add_count);
                        end else begin
                            // Only what fits in both the slot and the total is kept.
                            room_slot = int'(COUNT_MAX) - int'(slot_count[slot]);
                            room_total = int'(COUNT_MAX) - int'(owed_credits);
                            taken = (room_slot < room_total) ? room_slot : room_total;
                            if (int'(add_count) < taken) begin
                                taken = add_count;
                            end
                            slot_count[slot] = slot_count[slot] + COUNT_W'(taken);
                            owed_credits = owed_credits + COUNT_W'(taken);
                            dropped_total = dropped_total + DROP_W'(int'(add_count) - taken);
                        end
                    end
                    queue_result(KIND_STATUS, '0, '0, 1'b1);
                end
                MODE_FORGET: begin
                    slot = find_slot(handle);
                    if (slot >= 0) begin
                        owed_credits = owed_credits - slot_count[slot];
                        slot_used[slot] = 0;
                        slot_count[slot] = '0;
                    end
                    queue_result(KIND_STATUS, '0, '0, 1'b1);
                end
                MODE_FLUSH: begin
                    threshold = (flush_level == 0) ? COUNT_W'(1) : flush_level;
                    if (owed_credits != 0 && (force_flush || owed_credits >= threshold)) begin
                        for (int i = 0; i < MAX_LINKS_DEF && records < RESULT_LIMIT; i++) begin
                            if (slot_used[i] && slot_count[i] != 0) begin
                                owed_credits = owed_credits - slot_count[i];
                                queue_result(KIND_RECORD, slot_handle[i], slot_count[i], 1'b0);
                                slot_count[i] = '0;
                                records++;
                            end
                        end
                    end
                    if (records == 0) begin
                        queue_result(KIND_EMPTY, '0, '0, 1'b1);
                    end else begin
                        expected_results[$].last = 1'b1;
                    end
                end
                default: begin
                    // The unused mode only answers with a status.
                    queue_result(KIND_STATUS, '0, '0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] rec_handle,
                          logic [COUNT_W-1:0] rec_count, logic [COUNT_W-1:0] pending_after,
                          logic [DROP_W-1:0] dropped_after, logic last);
            credit_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d", kind));
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (rec_handle !== want.rec_handle)
                report_mismatch($sformatf("record_handle %h, want %h",
                                          rec_handle, want.rec_handle));
            if (rec_count !== want.rec_count)
                report_mismatch($sformatf("record_count %0d, want %0d",
                                          rec_count, want.rec_count));
            if (pending_after !== want.pending_after)
                report_mismatch($sformatf("pending_after %0d, want %0d",
                                          pending_after, want.pending_after));
            if (dropped_after !== want.dropped_after)
                report_mismatch($sformatf("dropped_after %0d, want %0d",
                                          dropped_after, want.dropped_after));
            if (last !== want.last)
                report_mismatch($sformatf("last %b, want %b", last, want.last));
        endtask
    endclass

    credit_scoreboard    board;
    logic [HANDLE_W-1:0] link_pool[POOL_SIZE];
    // When set, the matching side runs back to back with no idle cycles.
    bit                  steady_flow;
    bit                  steady_drain;
    int                  quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Present one request at a falling edge after a random idle gap, and hold it until
    // the tracker takes it at a rising edge. A zero gap keeps tvalid high between
    // requests so that a request is already waiting when the tracker becomes ready again.
    task automatic send_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                                logic [COUNT_W-1:0] add_count, logic force_flush);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'b0, add_count, handle};
        s_tuser = {force_flush, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(mode, handle, add_count, force_flush);
        if ($urandom_range(0, 29) == 0) begin
            steady_flow = !steady_flow;
        end
    endtask

    // Most requests work on a small pool of links so that slots fill up, get reused
    // and overflow; the rest use any handle so every handle bit toggles. Counts are
    // mostly small, with zeros and near-full values mixed in to reach both the zero
    // add and the overflow paths.
    task automatic random_request();
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [COUNT_W-1:0]  add_count;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) mode = MODE_ADD;
        else if (pick < 67) mode = MODE_FORGET;
        else if (pick < 95) mode = MODE_FLUSH;
        else mode = MODE_NONE;
        if ($urandom_range(0, 99) < 85) handle = link_pool[$urandom_range(0, POOL_SIZE - 1)];
        else handle = HANDLE_W'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 60) add_count = COUNT_W'($urandom_range(1, 16));
        else if (pick < 75) add_count = '0;
        else if (pick < 90) add_count = COUNT_W'($urandom_range(0, 65535));
        else add_count = COUNT_W'($urandom_range(60000, 65535));
        send_request(mode, handle, add_count, 1'($urandom_range(0, 1)));
    endtask

    // Drop tvalid and let every expected result come out, then wait SETTLE_CYCLES more
    // so the tracker is surely back in its idle state.
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [COUNT_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_threshold(value);
    endtask

    // Result side: stall a random number of cycles, then accept whatever comes next.
    initial begin
        int stall;
        m_tready = 1'b0;
        steady_drain = 0;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady_drain ? 0 : $urandom_range(0, GAP_MAX);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            board.check_result(m_tuser, m_tdata[11:0], m_tdata[27:12], m_tdata[43:28],
                               m_tdata[75:44], m_tlast);
            if ($urandom_range(0, 24) == 0) begin
                steady_drain = !steady_drain;
            end
        end
    end

    // Watchdog: a run that stops moving on both channels is a hang.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [COUNT_W-1:0] threshold_plan[4];
        logic [HANDLE_W-1:0] candidate;
        bit                  duplicate;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        steady_flow = 0;
        board = new();

        // Distinct links for the random part; eleven of them overfill the eight slots.
        for (int i = 0; i < POOL_SIZE; i++) begin
            do begin
                candidate = HANDLE_W'($urandom_range(0, 4095));
                duplicate = 0;
                for (int j = 0; j < i; j++) begin
                    if (link_pool[j] == candidate) duplicate = 1;
                end
            end while (duplicate);
            link_pool[i] = candidate;
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part, run with the reset threshold of one.
        // Flushes of an empty table, plain and forced, give an empty result.
        send_request(MODE_FLUSH, 12'h000, 16'h0000, 1'b0);
        send_request(MODE_FLUSH, 12'hfff, 16'hffff, 1'b1);
        // A zero add must not take a slot.
        send_request(MODE_ADD, 12'h000, 16'h0000, 1'b0);
        send_request(MODE_ADD, 12'hfff, 16'h0001, 1'b0);
        // The full count only partly fits in the pending total; the rest is dropped.
        send_request(MODE_ADD, 12'h000, 16'hffff, 1'b1);
        // With the total saturated, a further add is dropped whole.
        send_request(MODE_ADD, 12'hfff, 16'h0005, 1'b0);
        // Forgetting a link that was never seen changes nothing.
        send_request(MODE_FORGET, 12'h123, 16'h0000, 1'b0);
        // The unused mode only answers with a status.
        send_request(MODE_NONE, 12'habc, 16'h5555, 1'b1);
        // Due flush: both links come out in slot order.
        send_request(MODE_FLUSH, 12'h000, 16'h0000, 1'b0);
        send_request(MODE_FORGET, 12'hfff, 16'h0000, 1'b0);
        // Fill the seven free slots, then one more link that finds no slot.
        for (int i = 0; i < 7; i++) begin
            send_request(MODE_ADD, 12'h001 << i, COUNT_W'(i + 1), 1'b0);
        end
        send_request(MODE_ADD, 12'h080, 16'h0003, 1'b0);
        send_request(MODE_ADD, 12'h000, 16'h0002, 1'b0);
        // Every slot holds credits: the largest flush the table allows.
        send_request(MODE_FLUSH, 12'h000, 16'h0000, 1'b1);
        // Forget a link that still holds credits, then reuse its slot.
        send_request(MODE_ADD, 12'h010, 16'h0007, 1'b0);
        send_request(MODE_FORGET, 12'h010, 16'h0000, 1'b0);
        send_request(MODE_ADD, 12'h100, 16'h0009, 1'b0);
        send_request(MODE_FLUSH, 12'h100, 16'h0000, 1'b0);
        drain_block();

        // Random phases under different thresholds: zero (treated as one), the maximum,
        // a small random value, and back to one.
        threshold_plan[0] = '0;
        threshold_plan[1] = COUNT_MAX;
        threshold_plan[2] = COUNT_W'($urandom_range(2, 200));
        threshold_plan[3] = THRESH_RESET;
        for (int p = 0; p < 4; p++) begin
            write_threshold(threshold_plan[p]);
            repeat (PHASE_REQUESTS) random_request();
            drain_block();
        end

        if (board.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
